// File: design/lqa_pkg.sv
// Shared types and constants for the linear queue with average unit.
// Used by the controller, the datapath, the divider and the top level.
package lqa_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W     = 32;
  localparam int MEAN_W     = 40;
  localparam int FRAC_W     = 8;
  localparam int CAP_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int FUNC_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register index of the capacity register on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_AVERAGE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // Source of the payload of a result.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RDATA,
    SRC_MEAN
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                rd_head;     // read port addresses the head slot
    logic                enq_write;   // store the input word, bump the tail
    logic                deq_pop;     // retire the head entry
    logic                walk_init;   // walk pointer to head, clear sum and count
    logic                ptr_inc;     // advance the walk pointer
    logic                acc;         // add the read word to the running sum
    logic                div_start;   // start the mean division
    logic                emit;        // load the output register
    logic [STATUS_W-1:0] emit_status;
    src_t                emit_src;
    logic                emit_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // tail has reached the usable capacity
    logic no_entries;  // tail index is zero
    logic empty;       // nothing to walk between head and tail
    logic ptr_last;    // walk pointer is on the newest entry
    logic out_free;    // output register can take a transfer this cycle
    logic div_busy;    // divider still iterating
  } dp_stat_t;

endpackage

// File: design/linear_queue_with_average_unit.sv
// Linear array queue with average: an enqueue or dequeue result waits in S_RES for
// the output register, and the next item is taken once the controller is back in idle.
// Display loads one result per entry, alternating S_DISP and S_DWAIT between reads.
// Average walks the entries through S_ACC and S_DWAIT, starts the divider in S_AWAIT,
// waits in S_DIV and loads the mean from S_RES; output stalls hold back every load.
// Synchronous reset clears the indices, capacity is 64.
module linear_queue_with_average_unit #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [lqa_pkg::FUNC_W-1:0]     func,
  input  logic signed [lqa_pkg::DATA_W-1:0]     value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [lqa_pkg::STATUS_W-1:0]   status,
  output logic signed [lqa_pkg::DATA_W-1:0]     data,
  output logic signed [lqa_pkg::MEAN_W-1:0]     mean,
  output logic                                  last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [lqa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [lqa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [lqa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);
  import lqa_pkg::*;

  logic [CAP_W-1:0] capacity;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // Configuration port: one register, the usable capacity.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? CFG_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lqa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func    (func),
    .stat    (stat),
    .cmd     (cmd)
  );

  lqa_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .data     (data),
    .mean     (mean),
    .last     (last)
  );

endmodule

// File: design/lqa_div.sv
// Sequential restoring divider for the queue mean, one quotient bit per cycle.
// Depends on lqa_pkg for the fraction and mean widths.
module lqa_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           sum,
  input  logic        [CNT_W-1:0]           cnt,
  output logic                              busy,
  output logic signed [lqa_pkg::MEAN_W-1:0] quot
);
  import lqa_pkg::*;

  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] steps;
  logic              neg;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [CNT_W-1:0]  rem_next;
  logic [DVD_W-1:0]  qfull;

  // Magnitude of the scaled sum; the sign is applied after the division.
  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign trial    = {rem, quo[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  // Truncation toward zero falls out of dividing the magnitude.
  assign qfull = neg ? (~quo + DVD_W'(1)) : quo;
  assign quot  = signed'(qfull[MEAN_W-1:0]);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(DVD_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {mag, {FRAC_W{1'b0}}};
      rem <= '0;
      dvs <= cnt;
      neg <= sum[SUM_W-1];
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

// File: design/lqa_dp.sv
// Datapath of the queue: word store, head and tail indices, walk pointer,
// running sum, mean divider and the output register. Depends on lqa_pkg, lqa_div.
module lqa_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic        [lqa_pkg::CAP_W-1:0]    capacity,
  input  logic signed [lqa_pkg::DATA_W-1:0]   value,
  input  lqa_pkg::ctrl_cmd_t                  cmd,
  output lqa_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [lqa_pkg::STATUS_W-1:0] status,
  output logic signed [lqa_pkg::DATA_W-1:0]   data,
  output logic signed [lqa_pkg::MEAN_W-1:0]   mean,
  output logic                                last
);
  import lqa_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = DATA_W + $clog2(DEPTH);

  logic [DATA_W-1:0] store [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  next_slot;
  logic [IDX_W-1:0]  ptr;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]  cnt;

  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  head_plus;
  logic [CNT_W-1:0]  ptr_plus;
  logic signed [MEAN_W-1:0] quot;
  logic              div_busy;
  logic              out_free;

  // Usable capacity saturates at the store depth.
  assign cap = (capacity > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity[CNT_W-1:0];

  assign head_plus = CNT_W'(head) + CNT_W'(1);
  assign ptr_plus  = CNT_W'(ptr) + CNT_W'(1);
  assign out_free  = !out_valid || !out_stall;

  // Status toward the controller.
  always_comb begin
    stat.full       = next_slot >= cap;
    stat.no_entries = next_slot == '0;
    stat.empty      = (next_slot == '0) || (CNT_W'(head) >= next_slot);
    stat.ptr_last   = ptr_plus == next_slot;
    stat.out_free   = out_free;
    stat.div_busy   = div_busy;
  end

  // Word store with a registered read port.
  assign rd_addr = cmd.rd_head ? head : ptr;

  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      store[next_slot[IDX_W-1:0]] <= value;
    end
    rdata <= store[rd_addr];
  end

  // Head and tail indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      next_slot <= '0;
    end else if (cmd.enq_write) begin
      if (next_slot == '0) begin
        head <= '0;
      end
      next_slot <= next_slot + CNT_W'(1);
    end else if (cmd.deq_pop) begin
      if (head_plus >= next_slot) begin
        head      <= '0;
        next_slot <= '0;
      end else begin
        head <= head + IDX_W'(1);
      end
    end
  end

  // Walk pointer and running sum for display and average.
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      ptr <= head;
      sum <= '0;
      cnt <= '0;
    end else begin
      if (cmd.ptr_inc) begin
        ptr <= ptr + IDX_W'(1);
      end
      if (cmd.acc) begin
        sum <= sum + {{(SUM_W-DATA_W){rdata[DATA_W-1]}}, rdata};
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  lqa_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .sum  (sum),
    .cnt  (cnt),
    .busy (div_busy),
    .quot (quot)
  );

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload of a transfer.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.emit_status;
      data   <= (cmd.emit_src == SRC_RDATA) ? rdata : '0;
      mean   <= (cmd.emit_src == SRC_MEAN) ? quot : '0;
      last   <= cmd.emit_last;
    end
  end

endmodule

// File: design/lqa_ctrl.sv
// Controller state machine for the queue: decodes each operation, sequences
// the display and average walks and the division. Depends on lqa_pkg.
module lqa_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lqa_pkg::FUNC_W-1:0]        func,
  input  lqa_pkg::dp_stat_t                 stat,
  output lqa_pkg::ctrl_cmd_t                cmd
);
  import lqa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RES    = 7'b0000010,
    S_DISP   = 7'b0000100,
    S_DWAIT  = 7'b0001000,
    S_ACC    = 7'b0010000,
    S_AWAIT  = 7'b0100000,
    S_DIV    = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  src_t                res_src, res_src_next;
  logic                accept;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && (state == S_IDLE);

  // Next state, commands and the pending single result.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_src_next    = res_src;
    cmd             = '0;
    cmd.emit_src    = SRC_NONE;
    cmd.rd_head     = state == S_IDLE;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_src_next    = SRC_NONE;
          state_next      = S_RES;
          case (func)
            FUNC_ENQUEUE: begin
              if (stat.full) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                cmd.enq_write = 1'b1;
              end
            end
            FUNC_DEQUEUE: begin
              if (stat.no_entries) begin
                res_status_next = ST_EMPTY;
              end else begin
                cmd.deq_pop   = 1'b1;
                cmd.walk_init = 1'b1;
                res_src_next  = SRC_RDATA;
              end
            end
            FUNC_DISPLAY: begin
              if (stat.empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cmd.walk_init = 1'b1;
                state_next    = S_DISP;
              end
            end
            default: begin
              if (stat.empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                cmd.walk_init = 1'b1;
                res_src_next  = SRC_MEAN;
                state_next    = S_ACC;
              end
            end
          endcase
        end
      end

      // A single result waits for the output register.
      S_RES: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = res_status;
          cmd.emit_src    = res_src;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      // One transfer per held entry, oldest first.
      S_DISP: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_src    = SRC_RDATA;
          cmd.emit_last   = stat.ptr_last;
          cmd.ptr_inc     = 1'b1;
          state_next      = stat.ptr_last ? S_IDLE : S_DWAIT;
        end
      end

      // Read of the next entry is in flight; resume the walk that asked for it.
      S_DWAIT: begin
        state_next = (res_src == SRC_MEAN) ? S_ACC : S_DISP;
      end

      // Add the current entry; after the newest one the sum is complete.
      S_ACC: begin
        cmd.acc     = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next  = stat.ptr_last ? S_AWAIT : S_DWAIT;
      end

      // The sum and count are final: start the division.
      S_AWAIT: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end

      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_RES;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_OK;
      res_src    <= SRC_NONE;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_src    <= res_src_next;
    end
  end

endmodule

// File: bench/tb.sv
// Self-checking testbench for linear_queue_with_average_unit.
// Depends on lqa_pkg for field widths, operation, status and register codes; it
// predicts every result of the queue and compares each one field by field.
`timescale 1ns / 1ps

module tb;
  import lqa_pkg::*;

  localparam int QDEPTH         = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 40;
  localparam int ROUND_MAX      = 8;
  localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = CFG_ADDR_W'(4 * REG_CAPACITY);

  // One result as the block should produce it.
  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic signed [MEAN_W-1:0] mean;
    logic                     last;
  } queue_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [FUNC_W-1:0]          func = FUNC_ENQUEUE;
  logic signed [DATA_W-1:0]   value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   data;
  logic signed [MEAN_W-1:0]   mean;
  logic                       last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;

  // Queue state as the block should hold it.
  logic signed [DATA_W-1:0]   word_store [QDEPTH];
  logic [5:0]                 head_slot = '0;
  logic [6:0]                 tail_slot = '0;
  logic [CAP_W-1:0]           capacity_setting = CAP_RESET;
  queue_result_t              pending_results [$];

  int errors = 0;
  int items_in = 0;
  int results_out = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_served = 1'b0;
  int hold_left = 0;

  linear_queue_with_average_unit #(.DEPTH(QDEPTH)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .data(data), .mean(mean), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Number of slots an enqueue may use under the current capacity.
  function automatic int usable_slots();
    return (capacity_setting > QDEPTH) ? QDEPTH : int'(capacity_setting);
  endfunction

  function automatic void push_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] d,
                                      logic signed [MEAN_W-1:0] m, logic lst);
    queue_result_t r;
    r.status = st;
    r.data = d;
    r.mean = m;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one operation to the queue state and queue up the results it causes.
  function automatic void predict_op(logic [FUNC_W-1:0] op, logic signed [DATA_W-1:0] word);
    longint sum;
    longint cnt;
    longint quotient;
    case (op)
      FUNC_ENQUEUE: begin
        if (int'(tail_slot) >= usable_slots()) begin
          push_result(ST_OVERFLOW, '0, '0, 1'b1);
        end else begin
          if (tail_slot == 0) head_slot = '0;
          word_store[tail_slot[5:0]] = word;
          tail_slot = tail_slot + 7'd1;
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      FUNC_DEQUEUE: begin
        if (tail_slot == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          push_result(ST_OK, word_store[head_slot], '0, 1'b1);
          if (head_slot + 7'd1 >= tail_slot) begin
            head_slot = '0;
            tail_slot = '0;
          end else begin
            head_slot = head_slot + 6'd1;
          end
        end
      end
      default: begin
        if (tail_slot == 0 || head_slot >= tail_slot) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else if (op == FUNC_DISPLAY) begin
          for (int i = head_slot; i < tail_slot; i++)
            push_result(ST_OK, word_store[i], '0, i == tail_slot - 1);
        end else begin
          // Exact mean, scaled by 256 and truncated toward zero.
          sum = 0;
          cnt = 0;
          for (int i = head_slot; i < tail_slot; i++) begin
            sum += longint'(word_store[i]);
            cnt++;
          end
          quotient = (sum * 256) / cnt;
          push_result(ST_OK, '0, quotient[MEAN_W-1:0], 1'b1);
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer,
  // and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_op(func, value);
        items_in++;
      end
      if (out_valid && !out_stall) begin
        results_out++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, status %0d data %0h mean %0h last %0b",
                     $time, status, data, mean, last);
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.status, status);
          compare_field("data", want.data, data);
          compare_field("mean", want.mean, mean);
          compare_field("last", want.last, last);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one item, after a random idle gap, and wait until it is taken.
  task automatic send_item(input logic [FUNC_W-1:0] op, input logic signed [DATA_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the capacity register, then read it back.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= CFG_DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    capacity_setting = cap;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    compare_field("capacity readback", CFG_DATA_W'(cap), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct <= sender_pct;
    recv_stall_pct <= receiver_pct;
  endtask

  // Words biased toward the extremes of the signed range.
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Empty-queue cases, extreme words, and a mean that needs truncation.
  task automatic test_empty_and_extremes();
    set_idling(0, 0);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_AVERAGE, $urandom);
    send_item(FUNC_ENQUEUE, 32'sh7FFF_FFFF);
    send_item(FUNC_ENQUEUE, 32'sh8000_0000);
    send_item(FUNC_ENQUEUE, -32'sd1);
    send_item(FUNC_ENQUEUE, 32'sd0);
    send_item(FUNC_ENQUEUE, 32'sd1);
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_AVERAGE, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_AVERAGE, $urandom);
    repeat (3) send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_AVERAGE, $urandom);
    send_item(FUNC_ENQUEUE, -32'sd7);
    send_item(FUNC_ENQUEUE, 32'sd2);
    send_item(FUNC_ENQUEUE, 32'sd0);
    send_item(FUNC_AVERAGE, $urandom);
    repeat (3) send_item(FUNC_DEQUEUE, $urandom);
    drain();
  endtask

  // Capacity of one, zero, above the depth, and lowered below the fill level.
  task automatic test_capacity_settings();
    set_idling(31, 31);
    write_capacity(7'd1);
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_DEQUEUE, $urandom);
    drain();
    write_capacity(7'd0);
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    drain();
    // Full queue of the largest word gives the largest mean.
    write_capacity(7'd127);
    repeat (QDEPTH) send_item(FUNC_ENQUEUE, 32'sh7FFF_FFFF);
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_DISPLAY, $urandom);
    send_item(FUNC_AVERAGE, $urandom);
    send_item(FUNC_DEQUEUE, $urandom);
    send_item(FUNC_ENQUEUE, rand_word());
    drain();
    write_capacity(7'd3);
    send_item(FUNC_ENQUEUE, rand_word());
    send_item(FUNC_DISPLAY, $urandom);
    repeat (QDEPTH - 1) send_item(FUNC_DEQUEUE, $urandom);
    repeat (4) send_item(FUNC_ENQUEUE, rand_word());
    repeat (3) send_item(FUNC_DEQUEUE, $urandom);
    drain();
  endtask

  // Receiver holds off while items keep coming, then the sender waits it out.
  task automatic test_backpressure();
    set_idling(0, 0);
    write_capacity(7'd64);
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++)
      send_item((i % 5 == 4) ? FUNC_DISPLAY : FUNC_ENQUEUE, rand_word());
    hold_req <= 1'b0;
    drain();
    send_item(FUNC_AVERAGE, $urandom);
    repeat (25) send_item(FUNC_DEQUEUE, $urandom);
    drain();
  endtask

  // Short rounds that fill toward a small capacity and then empty, mixed with
  // random noise.
  task automatic run_random(input int count);
    int sent;
    int n;
    int fill_max;
    sent = 0;
    while (sent < count) begin
      fill_max = (usable_slots() + 1 < ROUND_MAX) ? usable_slots() + 1 : ROUND_MAX;
      if ($urandom_range(3) != 0) begin
        n = $urandom_range(1, fill_max);
        repeat (n) begin
          if ($urandom_range(9) == 0)
            send_item($urandom_range(1) ? FUNC_DISPLAY : FUNC_AVERAGE, $urandom);
          else
            send_item(FUNC_ENQUEUE, rand_word());
          sent++;
        end
        n = $urandom_range(1, fill_max);
        repeat (n) begin
          if ($urandom_range(9) == 0)
            send_item($urandom_range(1) ? FUNC_DISPLAY : FUNC_AVERAGE, $urandom);
          else
            send_item(FUNC_DEQUEUE, $urandom);
          sent++;
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_item(FUNC_W'($urandom_range(3)), rand_word());
          sent++;
        end
      end
    end
    drain();
  endtask

  // Four idling mixes, each under its own capacity.
  task automatic test_random_traffic();
    set_idling(0, 0);
    write_capacity(7'd4);
    run_random(8);
    set_idling(57, 0);
    write_capacity(CAP_W'($urandom_range(2, 12)));
    run_random(8);
    set_idling(0, 57);
    write_capacity(7'd64);
    run_random(8);
    set_idling(31, 31);
    write_capacity(CAP_W'($urandom_range(1, 8)));
    run_random(8);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_extremes();
    test_capacity_settings();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (200) @(posedge clk);
    $display("Run covered %0d input transfers and %0d results: empty-queue cases,",
             items_in, results_out);
    $display("capacities 0, 1, 3, 64, 127, a long receiver hold and four idling mixes.");
    if (pending_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
